// File: design/wam_pkg.sv
package wam_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_CMD    = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_PERIODIC  = 2'd0,
        KIND_REQUESTED = 2'd1,
        KIND_WIND      = 2'd2,
        KIND_CLIMATE   = 2'd3
    } kind_t;

    localparam logic [7:0] CMD_REPORT    = 8'h68;  // 'h'
    localparam logic [7:0] CMD_LIMITS_LO = 8'h41;  // 'A'
    localparam logic [7:0] CMD_LIMITS_HI = 8'h61;  // 'a'
    localparam logic [7:0] CMD_GUST_LO   = 8'h42;  // 'B'
    localparam logic [7:0] CMD_GUST_HI   = 8'h62;  // 'b'

    localparam logic REG_REPORT_PERIOD  = 1'b0;
    localparam logic REG_CAPTURE_PERIOD = 1'b1;

    localparam logic [15:0] REPORT_PERIOD_RESET  = 16'd60000;
    localparam logic [15:0] CAPTURE_PERIOD_RESET = 16'd1000;

    localparam logic [9:0]  TEMP_LIMIT_LO  = 10'd60;
    localparam logic [9:0]  HUM_LIMIT_LO   = 10'd30;
    localparam logic [15:0] SPEED_LIMIT_LO = 16'd150;
    localparam logic [9:0]  TEMP_LIMIT_HI  = 10'd100;
    localparam logic [9:0]  HUM_LIMIT_HI   = 10'd300;
    localparam logic [15:0] SPEED_LIMIT_HI = 16'd400;
    localparam logic [15:0] GUST_LIMIT_LO  = 16'd200;
    localparam logic [15:0] GUST_LIMIT_HI  = 16'd400;

    typedef struct packed {
        logic [15:0] tick_count;
        logic [15:0] capture_count;
        logic [15:0] speed_now;
        logic [15:0] speed_before;
        logic [9:0]  last_temperature;
        logic [9:0]  last_humidity;
        logic [9:0]  temperature_limit;
        logic [9:0]  humidity_limit;
        logic [15:0] speed_limit;
        logic [15:0] gust_limit;
        logic        wind_armed;
        logic        climate_armed;
    } wam_state_t;

    localparam wam_state_t STATE_RESET = '{
        tick_count:        16'd0,
        capture_count:     16'd0,
        speed_now:         16'd635,
        speed_before:      16'd635,
        last_temperature:  10'd0,
        last_humidity:     10'd0,
        temperature_limit: 10'd80,
        humidity_limit:    10'd60,
        speed_limit:       16'd300,
        gust_limit:        16'd300,
        wind_armed:        1'b1,
        climate_armed:     1'b1
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] pulse_count;
        logic [9:0]  temperature;
        logic [9:0]  humidity;
        logic [7:0]  command_byte;
    } wam_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  temperature;
        logic [9:0]  humidity;
        logic [15:0] speed;
        logic        clear_pulses;
    } wam_result_t;

endpackage

// File: design/wam_step.sv
module wam_step (
    input  wam_pkg::wam_state_t  state,
    input  wam_pkg::wam_item_t   item,
    input  logic [15:0]          report_period,
    input  logic [15:0]          capture_period,
    output wam_pkg::wam_state_t  state_next,
    output logic                 emit,
    output wam_pkg::wam_result_t result
);
    import wam_pkg::*;

    logic [15:0] tick_inc;
    logic [15:0] rise;
    logic        gust_hit;
    logic        climate_hit;
    kind_t       kind;
    logic        clear;

    assign tick_inc = state.tick_count + 16'd1;
    assign rise     = state.speed_now - state.speed_before;
    // The rise is signed while the gust limit is unsigned; compare at 17 bits.
    assign gust_hit = $signed({rise[15], rise}) >= $signed({1'b0, state.gust_limit});
    assign climate_hit = (item.temperature >= state.temperature_limit)
                      && (item.humidity <= state.humidity_limit)
                      && (state.speed_now >= state.speed_limit);

    always_comb
    begin
        state_next = state;
        emit       = 1'b0;
        kind       = KIND_PERIODIC;
        clear      = 1'b0;
        unique case (func_t'(item.func))
            FUNC_TICK:
            begin
                if (tick_inc == report_period)
                begin
                    state_next.tick_count = 16'd0;
                    emit = 1'b1;
                end
                else
                begin
                    state_next.tick_count = tick_inc;
                    if (state.capture_count == capture_period)
                    begin
                        state_next.capture_count = 16'd0;
                        state_next.speed_before  = state.speed_now;
                        state_next.speed_now     = item.pulse_count;
                        emit  = 1'b1;
                        clear = 1'b1;
                    end
                    else
                    begin
                        state_next.capture_count = state.capture_count + 16'd1;
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                state_next.last_temperature = item.temperature;
                state_next.last_humidity    = item.humidity;
                priority if (gust_hit && state.wind_armed)
                begin
                    state_next.wind_armed = 1'b0;
                    emit = 1'b1;
                    kind = KIND_WIND;
                end
                else if (!gust_hit && !state.wind_armed)
                begin
                    state_next.wind_armed = 1'b1;
                end
                else if (climate_hit && state.climate_armed)
                begin
                    state_next.climate_armed = 1'b0;
                    emit = 1'b1;
                    kind = KIND_CLIMATE;
                end
                else if ((item.humidity > state.humidity_limit) && !state.climate_armed)
                begin
                    state_next.climate_armed = 1'b1;
                end
            end
            FUNC_CMD:
            begin
                unique case (item.command_byte)
                    CMD_REPORT:
                    begin
                        emit = 1'b1;
                        kind = KIND_REQUESTED;
                    end
                    CMD_LIMITS_LO:
                    begin
                        state_next.temperature_limit = TEMP_LIMIT_LO;
                        state_next.humidity_limit    = HUM_LIMIT_LO;
                        state_next.speed_limit       = SPEED_LIMIT_LO;
                    end
                    CMD_LIMITS_HI:
                    begin
                        state_next.temperature_limit = TEMP_LIMIT_HI;
                        state_next.humidity_limit    = HUM_LIMIT_HI;
                        state_next.speed_limit       = SPEED_LIMIT_HI;
                    end
                    CMD_GUST_LO: state_next.gust_limit = GUST_LIMIT_LO;
                    CMD_GUST_HI: state_next.gust_limit = GUST_LIMIT_HI;
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Reports carry the state as it stands after this word is applied.
    always_comb
    begin
        result.kind         = kind;
        result.temperature  = state_next.last_temperature;
        result.humidity     = state_next.last_humidity;
        result.speed        = state_next.speed_now;
        result.clear_pulses = clear;
    end

endmodule

// File: design/weather_alarm_monitor_core.sv
// Channel  Handshake                 Payload
// in       in_valid / in_ready       func, pulse_count, temperature, humidity, command_byte
// out      out_valid / out_ready     report_kind, report_temperature, report_humidity,
//                                    report_speed, clear_pulses
// cfg      psel/penable/pwrite       paddr[2:0], pwdata, prdata, pready (always high)
//
// One word per cycle sustained while the output is not stalled: a word is registered
// on entry, then the rule logic updates the state and loads the result register on a report.
// rst_n clears the state, limits and periods to their defaults at once; no sweep.
// A stalled output holds the entry register; in_ready stays high while the result
// register is empty or is being taken.
module weather_alarm_monitor_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] pulse_count,
    input  logic [9:0]  temperature,
    input  logic [9:0]  humidity,
    input  logic [7:0]  command_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  report_kind,
    output logic [9:0]  report_temperature,
    output logic [9:0]  report_humidity,
    output logic [15:0] report_speed,
    output logic        clear_pulses,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wam_pkg::*;

    logic        in_valid_reg;
    wam_item_t   item_reg;
    wam_state_t  state_reg;
    wam_state_t  state_next;
    logic        out_valid_reg;
    wam_result_t result_reg;
    wam_result_t result_next;
    logic        emit;
    logic        advance;
    logic        cfg_write;
    logic [15:0] report_period_reg;
    logic [15:0] capture_period_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    wam_step u_step (
        .state          (state_reg),
        .item           (item_reg),
        .report_period  (report_period_reg),
        .capture_period (capture_period_reg),
        .state_next     (state_next),
        .emit           (emit),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{func, pulse_count, temperature, humidity, command_byte};
        if (advance && emit)
            result_reg <= result_next;
    end

    assign out_valid          = out_valid_reg;
    assign report_kind        = result_reg.kind;
    assign report_temperature = result_reg.temperature;
    assign report_humidity    = result_reg.humidity;
    assign report_speed       = result_reg.speed;
    assign clear_pulses       = result_reg.clear_pulses;

    // Register decode uses the word address only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_period_reg  <= REPORT_PERIOD_RESET;
            capture_period_reg <= CAPTURE_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_REPORT_PERIOD:  report_period_reg  <= pwdata[15:0];
                REG_CAPTURE_PERIOD: capture_period_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_REPORT_PERIOD:  prdata = {16'd0, report_period_reg};
            REG_CAPTURE_PERIOD: prdata = {16'd0, capture_period_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("result appeared without a word being processed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_pulses) |-> (report_kind == KIND_PERIODIC))
        else $error("speed capture result carries a non-periodic kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while the result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(item_reg)))
        else $error("held word lost or changed while waiting for output");

endmodule
